// ===== hw/rtl/delayed_register_write_scheduler_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Delayed register write scheduler - assertion macros
// Shared concurrent assertion forms, one clock and one active-high reset.
// ----------------------------------------------------------------------------
`ifndef DELAYED_REGISTER_WRITE_SCHEDULER_UNIT_DEFINES_SVH
`define DELAYED_REGISTER_WRITE_SCHEDULER_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define DRWS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("drws assertion failed");

// Consequent holds in the cycle after the antecedent.
`define DRWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drws assertion failed");

`endif

// ===== hw/rtl/drws_pkg.sv =====
// ----------------------------------------------------------------------------
// drws_pkg
// Types, codes and field layout shared by the write scheduler modules.
// ----------------------------------------------------------------------------
package drws_pkg;

   localparam int WRITE_SLOTS_DEF = 8;

   // field widths
   localparam int REQ_W  = 3;
   localparam int IDX_W  = 5;
   localparam int WORD_W = 32;
   localparam int LAT_W  = 8;
   localparam int KIND_W = 2;
   localparam int CLK_W  = 64;
   localparam int AGE_W  = 32;
   localparam int CNT_W  = 4;

   // tdata layout, same on both channels
   localparam int IDX_LSB = 0;
   localparam int VAL_LSB = IDX_LSB + IDX_W;
   localparam int HI_LSB  = VAL_LSB + WORD_W;
   localparam int LO_LSB  = HI_LSB + WORD_W;
   localparam int LAT_LSB = LO_LSB + WORD_W;
   localparam int USED_W  = LAT_LSB + LAT_W;
   localparam int TDATA_W = ((USED_W + 7) / 8) * 8;
   localparam int PAD_W   = TDATA_W - USED_W;
   localparam int REQ_USER_W = REQ_W;
   localparam int RSP_USER_W = KIND_W;

   // request codes
   localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DATA  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_CTRL  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_MULDV = 3'd3;
   localparam logic [REQ_W-1:0] REQ_BUSY  = 3'd4;
   localparam logic [REQ_W-1:0] REQ_STALL = 3'd5;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CTRL   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HILO   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REPORT = 2'd3;

   localparam logic [IDX_W-1:0] REG_SLOW = 5'd28;
   localparam logic [1:0]       DLY_FAST = 2'd2;
   localparam logic [1:0]       DLY_SLOW = 2'd3;

   // results allowed ahead of the end report
   localparam logic [CNT_W-1:0] RESULT_BUDGET = 4'd9;

   // clock update select
   localparam logic [1:0] CLK_HOLD = 2'd0;
   localparam logic [1:0] CLK_TICK = 2'd1;
   localparam logic [1:0] CLK_JUMP = 2'd2;
   localparam logic [1:0] CLK_MD   = 2'd3;

   // slot scan modes
   localparam logic SCAN_RETIRE = 1'b0;
   localparam logic SCAN_MIN    = 1'b1;

   typedef struct packed {
      logic       load;
      logic [1:0] clk_op;
      logic       busy_chk;
      logic       emit_md;
      logic       scan_start;
      logic       scan_step;
      logic       scan_mode;
      logic       emit_slot;
      logic       insert;
      logic       insert_high;
      logic       md_set;
      logic       busy_set;
      logic       emit_report;
   } drws_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_kind;
      logic             lat_zero;
      logic             md_stall;
      logic             md_emit_ok;
      logic             scan_last;
      logic             found;
      logic             budget_left;
      logic             free_any;
      logic             out_ready;
   } drws_stat_type;

endpackage

// ===== hw/rtl/drws_dpath.sv =====
// ----------------------------------------------------------------------------
// drws_dpath
// Clock, muldiv and busy state, write slot table, slot scanner, result register.
// ----------------------------------------------------------------------------
module drws_dpath #(
   parameter int WRITE_SLOTS = drws_pkg::WRITE_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  drws_pkg::drws_cmd_type              cmd,
   output drws_pkg::drws_stat_type             stat,
   input  logic [drws_pkg::TDATA_W-1:0]        req_tdata,
   input  logic [drws_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [drws_pkg::TDATA_W-1:0]        rsp_tdata,
   output logic [drws_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);
   import drws_pkg::*;

   localparam int IW = (WRITE_SLOTS > 1) ? $clog2(WRITE_SLOTS) : 1;

   // latched request
   logic [REQ_W-1:0]  rq_type_ff;
   logic [IDX_W-1:0]  rq_index_ff;
   logic [WORD_W-1:0] rq_value_ff, rq_hi_ff, rq_lo_ff;
   logic [LAT_W-1:0]  rq_lat_ff, lat_m1;

   // time and pending results
   logic [CLK_W-1:0]  clock_ff, clock_in;
   logic [LAT_W-1:0]  adv_ff, adv_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              md_pend_ff, md_pend_in;
   logic [CLK_W-1:0]  md_due_ff, md_due_in;
   logic [WORD_W-1:0] md_hi_ff, md_lo_ff;
   logic [CLK_W-1:0]  busy_ff, busy_in;

   // slot table
   logic [WRITE_SLOTS-1:0] slot_vld_ff;
   logic                   slot_ctrl_ff [WRITE_SLOTS];
   logic [IDX_W-1:0]       slot_reg_ff  [WRITE_SLOTS];
   logic [WORD_W-1:0]      slot_data_ff [WRITE_SLOTS];
   logic [CLK_W-1:0]       slot_due_ff  [WRITE_SLOTS];
   logic [AGE_W-1:0]       slot_age_ff  [WRITE_SLOTS];
   logic [AGE_W-1:0]       next_age_ff;

   // scanner
   logic [IW-1:0]     scan_idx_ff, scan_idx_in;
   logic              found_ff, found_in;
   logic [IW-1:0]     best_idx_ff;
   logic              best_ctrl_ff;
   logic [IDX_W-1:0]  best_reg_ff;
   logic [WORD_W-1:0] best_data_ff;
   logic [CLK_W-1:0]  best_due_ff;
   logic [AGE_W-1:0]  best_age_ff;
   logic              take;
   logic [CLK_W-1:0]  sc_due;
   logic [AGE_W-1:0]  sc_age;

   // free slot search and insert
   logic [IW-1:0]     free_lo, free_hi, tgt;
   logic [CLK_W-1:0]  ins_due;

   // result register
   logic              rsp_valid_ff, rsp_valid_in, out_load, out_ready;
   logic [KIND_W-1:0] o_kind_ff, o_kind_in;
   logic [IDX_W-1:0]  o_idx_ff, o_idx_in;
   logic [WORD_W-1:0] o_val_ff, o_val_in, o_hi_ff, o_hi_in, o_lo_ff, o_lo_in;
   logic [LAT_W-1:0]  o_cyc_ff, o_cyc_in;
   logic              o_last_ff, o_last_in;

   assign lat_m1 = (rq_lat_ff == '0) ? '0 : rq_lat_ff - LAT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rq_type_ff  <= req_tuser;
         rq_index_ff <= req_tdata[IDX_LSB +: IDX_W];
         rq_value_ff <= req_tdata[VAL_LSB +: WORD_W];
         rq_hi_ff    <= req_tdata[HI_LSB +: WORD_W];
         rq_lo_ff    <= req_tdata[LO_LSB +: WORD_W];
         rq_lat_ff   <= req_tdata[LAT_LSB +: LAT_W];
      end
   end

   // clock update and advance tally
   always_comb begin
      unique case (cmd.clk_op)
         CLK_HOLD: clock_in = clock_ff;
         CLK_TICK: clock_in = clock_ff + CLK_W'(rq_lat_ff);
         CLK_JUMP: clock_in = (best_due_ff <= clock_ff) ? clock_ff + CLK_W'(1) : best_due_ff;
         CLK_MD:   clock_in = md_due_ff;
      endcase
      if (cmd.load) begin
         adv_in = '0;
      end else begin
         adv_in = adv_ff + (clock_in[LAT_W-1:0] - clock_ff[LAT_W-1:0]);
      end
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.emit_md || cmd.emit_slot) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // muldiv and busy deadline
   always_comb begin
      md_pend_in = md_pend_ff;
      md_due_in  = md_due_ff;
      busy_in    = busy_ff;
      if (cmd.md_set) begin
         md_pend_in = 1'b1;
         md_due_in  = clock_ff + CLK_W'(lat_m1);
      end else if (cmd.emit_md) begin
         md_pend_in = 1'b0;
      end
      if (cmd.busy_set) begin
         busy_in = clock_ff + CLK_W'(lat_m1);
      end else if (cmd.busy_chk && busy_ff != '0 && busy_ff <= clock_ff) begin
         busy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff   <= '0;
         adv_ff     <= '0;
         cnt_ff     <= '0;
         md_pend_ff <= 1'b0;
         md_due_ff  <= '0;
         busy_ff    <= '0;
      end else begin
         clock_ff   <= clock_in;
         adv_ff     <= adv_in;
         cnt_ff     <= cnt_in;
         md_pend_ff <= md_pend_in;
         md_due_ff  <= md_due_in;
         busy_ff    <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.md_set) begin
         md_hi_ff <= rq_hi_ff;
         md_lo_ff <= rq_lo_ff;
      end
   end

   // one slot per cycle against the running best
   assign sc_due = slot_due_ff[scan_idx_ff];
   assign sc_age = slot_age_ff[scan_idx_ff];

   always_comb begin
      if (cmd.scan_mode == SCAN_MIN) begin
         take = !found_ff || (sc_due < best_due_ff);
      end else begin
         take = slot_vld_ff[scan_idx_ff] && (sc_due <= clock_ff) &&
                (!found_ff || (sc_due < best_due_ff) ||
                 ((sc_due == best_due_ff) && (sc_age < best_age_ff)));
      end
      scan_idx_in = scan_idx_ff;
      found_in    = found_ff;
      if (cmd.scan_start) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
      end else if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IW'(1);
         found_in    = found_ff | take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         found_ff    <= 1'b0;
      end else begin
         scan_idx_ff <= scan_idx_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && take) begin
         best_idx_ff  <= scan_idx_ff;
         best_ctrl_ff <= slot_ctrl_ff[scan_idx_ff];
         best_reg_ff  <= slot_reg_ff[scan_idx_ff];
         best_data_ff <= slot_data_ff[scan_idx_ff];
         best_due_ff  <= sc_due;
         best_age_ff  <= sc_age;
      end
   end

   // lowest and highest free slot
   always_comb begin
      free_lo = '0;
      free_hi = '0;
      for (int i = WRITE_SLOTS - 1; i >= 0; i--) begin
         if (!slot_vld_ff[i]) free_lo = IW'(i);
      end
      for (int i = 0; i < WRITE_SLOTS; i++) begin
         if (!slot_vld_ff[i]) free_hi = IW'(i);
      end
      tgt = cmd.insert_high ? free_hi : free_lo;
      if (rq_type_ff == REQ_CTRL || rq_index_ff == REG_SLOW) begin
         ins_due = clock_ff + CLK_W'(DLY_SLOW);
      end else begin
         ins_due = clock_ff + CLK_W'(DLY_FAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         next_age_ff <= '0;
      end else if (cmd.insert) begin
         slot_vld_ff[tgt] <= 1'b1;
         next_age_ff      <= next_age_ff + AGE_W'(1);
      end else if (cmd.emit_slot) begin
         slot_vld_ff[best_idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         slot_ctrl_ff[tgt] <= (rq_type_ff == REQ_CTRL);
         slot_reg_ff[tgt]  <= rq_index_ff;
         slot_data_ff[tgt] <= rq_value_ff;
         slot_due_ff[tgt]  <= ins_due;
         slot_age_ff[tgt]  <= next_age_ff;
      end
   end

   // result register
   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign out_load  = cmd.emit_md || cmd.emit_slot || cmd.emit_report;

   always_comb begin
      o_kind_in = KIND_REPORT;
      o_idx_in  = '0;
      o_val_in  = '0;
      o_hi_in   = '0;
      o_lo_in   = '0;
      o_cyc_in  = '0;
      o_last_in = 1'b0;
      priority if (cmd.emit_md) begin
         o_kind_in = KIND_HILO;
         o_hi_in   = md_hi_ff;
         o_lo_in   = md_lo_ff;
      end else if (cmd.emit_slot) begin
         o_kind_in = best_ctrl_ff ? KIND_CTRL : KIND_DATA;
         o_idx_in  = best_reg_ff;
         o_val_in  = best_data_ff;
      end else begin
         o_cyc_in  = adv_ff;
         o_last_in = 1'b1;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         o_kind_ff <= o_kind_in;
         o_idx_ff  <= o_idx_in;
         o_val_ff  <= o_val_in;
         o_hi_ff   <= o_hi_in;
         o_lo_ff   <= o_lo_in;
         o_cyc_ff  <= o_cyc_in;
         o_last_ff <= o_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, o_cyc_ff, o_lo_ff, o_hi_ff, o_val_ff, o_idx_ff};

   // status to the controller
   always_comb begin
      stat.req_kind    = rq_type_ff;
      stat.lat_zero    = (rq_lat_ff == '0);
      stat.md_stall    = md_pend_ff && (md_due_ff > clock_ff);
      stat.budget_left = (cnt_ff < RESULT_BUDGET);
      stat.md_emit_ok  = md_pend_ff && (md_due_ff <= clock_ff) && stat.budget_left;
      stat.scan_last   = (scan_idx_ff == IW'(WRITE_SLOTS - 1));
      stat.found       = found_ff;
      stat.free_any    = ~&slot_vld_ff;
      stat.out_ready   = out_ready;
   end

endmodule

// ===== hw/rtl/drws_ctrl.sv =====
// ----------------------------------------------------------------------------
// drws_ctrl
// Sequencer for one request: dispatch, advance, retire scans, insert, report.
// ----------------------------------------------------------------------------
module drws_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  drws_pkg::drws_stat_type stat,
   output drws_pkg::drws_cmd_type  cmd
);
   import drws_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_ADVMD    = 4'd2;
   localparam logic [3:0] S_RSTART   = 4'd3;
   localparam logic [3:0] S_RSCAN    = 4'd4;
   localparam logic [3:0] S_RDONE    = 4'd5;
   localparam logic [3:0] S_AFTER    = 4'd6;
   localparam logic [3:0] S_FREE     = 4'd7;
   localparam logic [3:0] S_MSCAN    = 4'd8;
   localparam logic [3:0] S_MJUMP    = 4'd9;
   localparam logic [3:0] S_REPORT   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       is_write;

   assign is_write   = (stat.req_kind == REQ_DATA) || (stat.req_kind == REQ_CTRL);
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd        = '0;
      cmd.clk_op = CLK_HOLD;
      state_in   = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.req_kind)
               REQ_TICK: begin
                  if (stat.lat_zero) begin
                     state_in = S_REPORT;
                  end else begin
                     cmd.clk_op = CLK_TICK;
                     state_in   = S_ADVMD;
                  end
               end
               REQ_DATA, REQ_CTRL: state_in = S_FREE;
               REQ_MULDV: begin
                  cmd.md_set = 1'b1;
                  state_in   = S_REPORT;
               end
               REQ_BUSY: begin
                  cmd.busy_set = 1'b1;
                  state_in     = S_REPORT;
               end
               REQ_STALL: begin
                  if (stat.md_stall) begin
                     cmd.clk_op = CLK_MD;
                     state_in   = S_ADVMD;
                  end else begin
                     state_in = S_REPORT;
                  end
               end
               default: state_in = S_REPORT;
            endcase
         end
         S_ADVMD: begin
            cmd.busy_chk = 1'b1;
            if (!stat.md_emit_ok) begin
               state_in = S_RSTART;
            end else if (stat.out_ready) begin
               cmd.emit_md = 1'b1;
               state_in    = S_RSTART;
            end
         end
         S_RSTART: begin
            if (stat.budget_left) begin
               cmd.scan_start = 1'b1;
               state_in       = S_RSCAN;
            end else begin
               state_in = S_AFTER;
            end
         end
         S_RSCAN: begin
            cmd.scan_step = 1'b1;
            cmd.scan_mode = SCAN_RETIRE;
            if (stat.scan_last) state_in = S_RDONE;
         end
         S_RDONE: begin
            if (!stat.found) begin
               state_in = S_AFTER;
            end else if (stat.out_ready) begin
               cmd.emit_slot = 1'b1;
               state_in      = S_RSTART;
            end
         end
         S_AFTER: begin
            if (!is_write) begin
               state_in = S_REPORT;
            end else if (stat.budget_left) begin
               state_in = S_FREE;
            end else begin
               // budget spent: take the highest free slot, if any
               cmd.insert      = stat.free_any;
               cmd.insert_high = 1'b1;
               state_in        = S_REPORT;
            end
         end
         S_FREE: begin
            if (stat.free_any) begin
               cmd.insert = 1'b1;
               state_in   = S_REPORT;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_MSCAN;
            end
         end
         S_MSCAN: begin
            cmd.scan_step = 1'b1;
            cmd.scan_mode = SCAN_MIN;
            if (stat.scan_last) state_in = S_MJUMP;
         end
         S_MJUMP: begin
            cmd.clk_op = CLK_JUMP;
            state_in   = S_ADVMD;
         end
         S_REPORT: begin
            if (stat.out_ready) begin
               cmd.emit_report = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/delayed_register_write_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// delayed_register_write_scheduler_unit
// Sequence: muldiv, busy, zero tick and unknown requests go from dispatch
// straight to the end report; a write into a free slot is inserted first. An
// advancing tick or stall runs the hi/lo check and the retire scans, one more
// scan per retired write; a full table adds the deadline search first. A result
// held by rsp_tready stalls the sequence until taken. Throughput: one request
// at a time, the next accept comes after the end report loads.
// Reset (synchronous): clock, deadlines and slot valid bits clear.
// ----------------------------------------------------------------------------
module delayed_register_write_scheduler_unit #(
   parameter int WRITE_SLOTS = drws_pkg::WRITE_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: reg_index[4:0], reg_value[36:5], hi_word[68:37], lo_word[100:69],
   //        latency[108:101], zero pad[111:109]
   input  logic [drws_pkg::TDATA_W-1:0]    req_tdata,
   // tuser: req_type[2:0]
   input  logic [drws_pkg::REQ_USER_W-1:0] req_tuser,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: out_index[4:0], out_value[36:5], out_hi[68:37], out_lo[100:69],
   //        cycles_advanced[108:101], zero pad[111:109]
   output logic [drws_pkg::TDATA_W-1:0]    rsp_tdata,
   // tuser: out_kind[1:0]
   output logic [drws_pkg::RSP_USER_W-1:0] rsp_tuser,
   // tlast: last_of_run, set on the end report only
   output logic                            rsp_tlast
);
   import drws_pkg::*;

   // Controller and datapath talk only through these two bundles.
   drws_cmd_type  cmd;
   drws_stat_type stat;

   // Sequencer: takes a request in idle, then walks through those steps it needs
   // of the advance, the hi/lo check, repeated retire scans, the deadline search
   // and the slot insert, and ends every request with the end report.
   drws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath: cycle clock, pending hi/lo, busy deadline, slot table with
   // age stamps, a serial scanner that holds the best slot found so far (earliest
   // due write, oldest on a tie, or earliest deadline when the table is full), and
   // the result register that lets a result wait while work goes on.
   drws_dpath #(
      .WRITE_SLOTS (WRITE_SLOTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/drws_checker.sv =====
// ----------------------------------------------------------------------------
// drws_checker
// Port-level checks on the write scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "delayed_register_write_scheduler_unit_defines.svh"

module drws_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [drws_pkg::TDATA_W-1:0]    rsp_tdata,
   input logic [drws_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                            rsp_tlast
);
   import drws_pkg::*;

   // one request in flight
   `DRWS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // when ready for a request, only the end report may still wait
   `DRWS_ASSERT_NOW(a_idle_report_only, clock, reset, req_tready && rsp_tvalid, rsp_tlast)

   // hi/lo result carries no register write and is never last
   `DRWS_ASSERT_NOW(a_hilo_clean, clock, reset, rsp_tvalid && rsp_tuser == KIND_HILO, rsp_tdata[HI_LSB-1:IDX_LSB] == '0 && !rsp_tlast)

   // stalled result holds
   `DRWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind delayed_register_write_scheduler_unit drws_checker u_drws_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - delayed register write scheduler testbench
// Drives requests on the stream input, predicts every retired write, hi/lo
// update and end report with a software copy of the scheduler
// state, and checks each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
   import drws_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = WRITE_SLOTS_DEF;

   // request codes the block ignores apart from the end report
   localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

   // slot occupancy in the shadow table
   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_DATA  = 2'd1;
   localparam logic [1:0] SLOT_CTRL  = 2'd2;

   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  index;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] lo;
      logic [LAT_W-1:0]  cycles;
      logic              last;
   } sched_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   int send_idle_pct = 20;
   int recv_idle_pct = 74;
   int mismatch_count = 0;

   sched_result_type expected_q[$];

   // shadow scheduler state
   logic [CLK_W-1:0]  sim_clock;
   logic              md_pending;
   logic [CLK_W-1:0]  md_due;
   logic [WORD_W-1:0] md_hi;
   logic [WORD_W-1:0] md_lo;
   logic [CLK_W-1:0]  busy_until;
   logic [1:0]        slot_kind  [SLOTS];
   logic [IDX_W-1:0]  slot_reg   [SLOTS];
   logic [WORD_W-1:0] slot_data  [SLOTS];
   logic [CLK_W-1:0]  slot_due   [SLOTS];
   logic [AGE_W-1:0]  slot_age   [SLOTS];
   logic [AGE_W-1:0]  age_count;
   int                item_results;
   logic [CLK_W-1:0]  item_adv;

   delayed_register_write_scheduler_unit #(.WRITE_SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------- shadow model

   function automatic void clear_shadow();
      sim_clock  = '0;
      md_pending = 1'b0;
      md_due     = '0;
      md_hi      = '0;
      md_lo      = '0;
      busy_until = '0;
      age_count  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_kind[i] = SLOT_EMPTY;
         slot_reg[i]  = '0;
         slot_data[i] = '0;
         slot_due[i]  = '0;
         slot_age[i]  = '0;
      end
   endfunction

   function automatic void push_result(input logic [KIND_W-1:0] kind,
                                       logic [IDX_W-1:0] index,
                                       logic [WORD_W-1:0] value, hi, lo,
                                       logic [LAT_W-1:0] cycles,
                                       logic last);
      sched_result_type r;
      r.kind   = kind;
      r.index  = index;
      r.value  = value;
      r.hi     = hi;
      r.lo     = lo;
      r.cycles = cycles;
      r.last   = last;
      expected_q.push_back(r);
      item_results++;
   endfunction

   // move the clock forward, then retire hi/lo and due writes within budget
   function automatic void advance_clock(input logic [CLK_W-1:0] n);
      int best;
      if (n == 0)
         return;
      sim_clock += n;
      item_adv  += n;
      if (md_pending && md_due <= sim_clock && item_results < RESULT_BUDGET) begin
         push_result(KIND_HILO, '0, '0, md_hi, md_lo, '0, 1'b0);
         md_pending = 1'b0;
         md_due     = '0;
         md_hi      = '0;
         md_lo      = '0;
      end
      if (busy_until != 0 && busy_until <= sim_clock)
         busy_until = '0;
      while (item_results < RESULT_BUDGET) begin
         best = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_kind[i] == SLOT_EMPTY || slot_due[i] > sim_clock)
               continue;
            if (best < 0 || slot_due[i] < slot_due[best] ||
                (slot_due[i] == slot_due[best] && slot_age[i] < slot_age[best]))
               best = i;
         end
         if (best < 0)
            break;
         push_result((slot_kind[best] == SLOT_DATA) ? KIND_DATA : KIND_CTRL,
                     slot_reg[best], slot_data[best], '0, '0, '0, 1'b0);
         slot_kind[best] = SLOT_EMPTY;
         slot_reg[best]  = '0;
         slot_data[best] = '0;
         slot_due[best]  = '0;
         slot_age[best]  = '0;
      end
   endfunction

   function automatic void schedule_write(input logic [1:0] kind,
                                          logic [IDX_W-1:0] index,
                                          logic [WORD_W-1:0] value,
                                          logic [CLK_W-1:0] delay);
      int target;
      logic [CLK_W-1:0] earliest;
      target = -1;
      while (1) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_kind[i] == SLOT_EMPTY) begin
               target = i;
               break;
            end
         end
         if (target >= 0)
            break;
         // table full: jump to the earliest deadline
         earliest = '1;
         for (int i = 0; i < SLOTS; i++)
            if (slot_due[i] < earliest)
               earliest = slot_due[i];
         if (earliest <= sim_clock)
            earliest = sim_clock + CLK_W'(1);
         advance_clock(earliest - sim_clock);
         if (item_results >= RESULT_BUDGET) begin
            // budget spent: the highest free slot wins, or the write is lost
            for (int i = 0; i < SLOTS; i++)
               if (slot_kind[i] == SLOT_EMPTY)
                  target = i;
            if (target < 0)
               return;
            break;
         end
      end
      slot_kind[target] = kind;
      slot_reg[target]  = index;
      slot_data[target] = value;
      slot_due[target]  = sim_clock + delay;
      slot_age[target]  = age_count;
      age_count++;
   endfunction

   function automatic void predict_request(input logic [REQ_W-1:0] kind,
                                           logic [IDX_W-1:0] index,
                                           logic [WORD_W-1:0] value, hi, lo,
                                           logic [LAT_W-1:0] lat);
      logic [CLK_W-1:0] eff_lat;
      item_results = 0;
      item_adv     = '0;
      eff_lat      = (lat == '0) ? CLK_W'(1) : CLK_W'(lat);
      case (kind)
         REQ_TICK:  advance_clock(CLK_W'(lat));
         REQ_DATA:  schedule_write(SLOT_DATA, index, value,
                                   CLK_W'((index == REG_SLOW) ? DLY_SLOW : DLY_FAST));
         REQ_CTRL:  schedule_write(SLOT_CTRL, index, value, CLK_W'(DLY_SLOW));
         REQ_MULDV: begin
            // a new result silently replaces a pending one
            md_pending = 1'b1;
            md_due     = sim_clock + eff_lat - CLK_W'(1);
            md_hi      = hi;
            md_lo      = lo;
         end
         REQ_BUSY:  busy_until = sim_clock + eff_lat - CLK_W'(1);
         REQ_STALL: begin
            if (md_pending && md_due > sim_clock)
               advance_clock(md_due - sim_clock);
         end
         default: ;
      endcase
      push_result(KIND_REPORT, '0, '0, '0, '0, item_adv[LAT_W-1:0], 1'b1);
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic send_request(input logic [REQ_W-1:0] kind,
                               logic [IDX_W-1:0] index,
                               logic [WORD_W-1:0] value, hi, lo,
                               logic [LAT_W-1:0] lat);
      logic [TDATA_W-1:0] word;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      word = '0;
      word[IDX_LSB +: IDX_W]  = index;
      word[VAL_LSB +: WORD_W] = value;
      word[HI_LSB +: WORD_W]  = hi;
      word[LO_LSB +: WORD_W]  = lo;
      word[LAT_LSB +: LAT_W]  = lat;
      req_tdata  <= word;
      req_tuser  <= kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_request(kind, index, value, hi, lo, lat);
   endtask

   function automatic logic [LAT_W-1:0] pick_latency();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return LAT_W'($urandom_range(0, 6));
      else if (r < 90)
         return LAT_W'($urandom_range(7, 40));
      return LAT_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [IDX_W-1:0] pick_register();
      if ($urandom_range(3) == 0)
         return REG_SLOW;
      return IDX_W'($urandom_range(0, 31));
   endfunction

   task automatic send_random_write();
      if ($urandom_range(9) < 7)
         send_request(REQ_DATA, pick_register(), $urandom, $urandom, $urandom, pick_latency());
      else
         send_request(REQ_CTRL, pick_register(), $urandom, $urandom, $urandom, pick_latency());
   endtask

   // ---------------------------------------------------------------- tests

   // due-time order first, age order on equal deadlines, zero-length tick
   task automatic test_write_ordering();
      send_request(REQ_TICK, '0, '0, '0, '0, 8'd0);
      send_request(REQ_DATA, REG_SLOW, 32'hFFFF_FFFF, '0, '0, '0);
      send_request(REQ_DATA, 5'd0, 32'h0000_0000, '1, '1, 8'hFF);
      send_request(REQ_CTRL, 5'd31, 32'hA5A5_5A5A, '0, '0, '0);
      send_request(REQ_TICK, '0, '0, '0, '0, 8'd3);
   endtask

   // zero latency, widest tick, replacement of a pending result, stall
   task automatic test_muldiv_result();
      send_request(REQ_MULDV, '0, '0, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0);
      send_request(REQ_TICK, '0, '0, '0, '0, 8'd255);
      send_request(REQ_MULDV, '0, '0, 32'h0000_0000, 32'hFFFF_FFFF, 8'd255);
      send_request(REQ_MULDV, '0, '0, 32'h1234_5678, 32'h9ABC_DEF0, 8'd10);
      send_request(REQ_STALL, '0, '0, '0, '0, '0);
      send_request(REQ_STALL, '0, '0, '0, '0, '0);
   endtask

   task automatic test_busy_and_spare_codes();
      send_request(REQ_BUSY, '0, '0, '0, '0, 8'd0);
      send_request(REQ_BUSY, '0, '0, '0, '0, 8'd255);
      send_request(REQ_SPARE_A, 5'd31, '1, '1, '1, 8'hFF);
      send_request(REQ_SPARE_B, '0, '0, '0, '0, '0);
   endtask

   // fill every slot, then a write forces a jump that spends the whole budget
   task automatic test_full_table();
      logic [IDX_W-1:0] regs [8] = '{5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd3, 5'd5, 5'd30};
      for (int i = 0; i < SLOTS; i++)
         send_request(REQ_DATA, regs[i % 8], $urandom, '0, '0, '0);
      send_request(REQ_MULDV, '0, '0, $urandom, $urandom, 8'd1);
      send_request(REQ_CTRL, 5'd31, $urandom, '0, '0, '0);
   endtask

   task automatic test_random_traffic(input int count);
      int sent;
      int r;
      int burst;
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(99);
         if (r < 8) begin
            // write burst, usually enough to overflow the table
            burst = $urandom_range(SLOTS, SLOTS + 3);
            repeat (burst) send_random_write();
            sent += burst;
         end else if (r < 34) begin
            send_request(REQ_TICK, IDX_W'($urandom), $urandom, $urandom, $urandom,
                         pick_latency());
            sent++;
         end else if (r < 60) begin
            send_random_write();
            sent++;
         end else if (r < 72) begin
            send_request(REQ_MULDV, IDX_W'($urandom), $urandom, $urandom, $urandom,
                         pick_latency());
            sent++;
         end else if (r < 78) begin
            send_request(REQ_BUSY, IDX_W'($urandom), $urandom, $urandom, $urandom,
                         pick_latency());
            sent++;
         end else if (r < 94) begin
            send_request(REQ_STALL, IDX_W'($urandom), $urandom, $urandom, $urandom,
                         LAT_W'($urandom));
            sent++;
         end else begin
            send_request($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B,
                         IDX_W'($urandom), $urandom, $urandom, $urandom, LAT_W'($urandom));
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, logic [63:0] want, got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      sched_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: kind %0d", rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("out_kind", want.kind, rsp_tuser);
            check_field("out_index", want.index, rsp_tdata[IDX_LSB +: IDX_W]);
            check_field("out_value", want.value, rsp_tdata[VAL_LSB +: WORD_W]);
            check_field("out_hi", want.hi, rsp_tdata[HI_LSB +: WORD_W]);
            check_field("out_lo", want.lo, rsp_tdata[LO_LSB +: WORD_W]);
            check_field("cycles_advanced", want.cycles, rsp_tdata[LAT_LSB +: LAT_W]);
            check_field("last_of_run", want.last, rsp_tlast);
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_shadow();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 74;
      test_write_ordering();
      test_muldiv_result();
      test_busy_and_spare_codes();
      test_full_table();
      test_random_traffic(160);

      send_idle_pct = 74;
      recv_idle_pct = 20;
      test_random_traffic(170);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(170);

      req_tvalid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
